FILE: design/cfr_pkg.sv
// shared types, codes and helper functions of the chunked frame reassembler
package cfr_pkg;

	// input commands
	localparam logic [1:0] CMD_FRAME = 2'd0;
	localparam logic [1:0] CMD_READ  = 2'd1;
	localparam logic [1:0] CMD_CLEAR = 2'd2;

	// result status codes
	localparam logic [2:0] ST_OK        = 3'd0;
	localparam logic [2:0] ST_DONE      = 3'd1;
	localparam logic [2:0] ST_FRAME_ERR = 3'd2;
	localparam logic [2:0] ST_CRC_ERR   = 3'd3;
	localparam logic [2:0] ST_READ      = 3'd4;

	// frame layout and crc constants
	localparam logic [7:0]  MAGIC_RESET = 8'hA5;
	localparam logic [15:0] CRC_INIT    = 16'hFFFF;
	localparam logic [15:0] CRC_POLY    = 16'h1021;
	localparam logic [16:0] HDR_BYTES   = 17'd6;
	localparam logic [16:0] TRL_BYTES   = 17'd2;
	localparam logic [16:0] FRAME_MIN   = 17'd8;
	localparam logic [16:0] COUNT_MAX   = 17'h1FFFF;

	// one input word
	typedef struct packed {
		logic [1:0]  command;
		logic [7:0]  data_byte;
		logic        end_of_frame;
		logic [13:0] read_address;
	} in_word_t;

	// result info handed from the control stage to the output stage
	typedef struct packed {
		logic        is_read;
		logic        in_range;
		logic [2:0]  status;
		logic [15:0] message_length;
		logic [14:0] received_count;
	} result_t;

	// crc-16/ccitt-false update by one byte, msb first
	function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] b);
		logic [15:0] c;
		c = crc_in ^ {b, 8'h00};
		for (int i = 0; i < 8; i++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

FILE: design/cfr_in_if.sv
// input word channel of the reassembler
interface cfr_in_if;
	logic        valid;
	logic        ready;
	logic [1:0]  command;
	logic [7:0]  data_byte;
	logic        end_of_frame;
	logic [13:0] read_address;

	modport source(output valid, command, data_byte, end_of_frame, read_address, input ready);
	modport sink(input valid, command, data_byte, end_of_frame, read_address, output ready);
endinterface

FILE: design/cfr_out_if.sv
// result word channel of the reassembler
interface cfr_out_if;
	logic        valid;
	logic        ready;
	logic [2:0]  status;
	logic [7:0]  read_data;
	logic [15:0] message_length;
	logic [14:0] received_count;

	modport source(output valid, status, read_data, message_length, received_count, input ready);
	modport sink(input valid, status, read_data, message_length, received_count, output ready);
endinterface

FILE: design/cfr_cfg_if.sv
// configuration write channel carrying the frame magic register
interface cfr_cfg_if;
	logic       valid;
	logic       ready;
	logic [7:0] data;

	modport source(output valid, data, input ready);
	modport sink(input valid, data, output ready);
endinterface

FILE: design/cfr_ram.sv
// generic single write, single read ram with registered read data
module cfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

FILE: design/cfr_frame_ctrl.sv
// frame parser, crc, verdict logic and reassembly counters; drives the buffer ram
module cfr_frame_ctrl #(
	parameter int BUFFER_BYTES = 16384
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            accept,
	input  cfr_pkg::in_word_t               word,
	input  logic                            cfg_we,
	input  logic [7:0]                      cfg_data,
	output logic                            res_valid,
	output cfr_pkg::result_t                res,
	output logic                            ram_we,
	output logic [$clog2(BUFFER_BYTES)-1:0] ram_waddr,
	output logic [7:0]                      ram_wdata,
	output logic                            ram_re,
	output logic [$clog2(BUFFER_BYTES)-1:0] ram_raddr
);

	localparam int AW = $clog2(BUFFER_BYTES);
	localparam int CW = $clog2(BUFFER_BYTES + 1);
	localparam logic [17:0] BUF_LIMIT = 18'(BUFFER_BYTES);

	// reassembly and frame state
	logic [CW-1:0] committed_q;
	logic [15:0]   exp_total_q;
	logic [7:0]    exp_chunk_q;
	logic [16:0]   fbc_q;
	logic [47:0]   hdr_q;
	logic [15:0]   crc_q;
	logic [15:0]   rcrc_q;
	logic [7:0]    magic_q;

	// per-byte next values
	logic [16:0] off;
	logic [16:0] trl_off;
	logic        is_hdr;
	logic        is_pay;
	logic        is_trl;
	logic [15:0] clen_q;
	logic [7:0]  chunk_q;
	logic [17:0] base;
	logic [17:0] waddr_full;
	logic [47:0] hdr_n;
	logic [15:0] crc_n;
	logic [15:0] rcrc_n;
	logic [16:0] fbc_n;

	// verdict values
	logic [7:0]    v_magic;
	logic [15:0]   v_total;
	logic [7:0]    v_chunk;
	logic [15:0]   v_clen;
	logic [17:0]   v_base;
	logic [17:0]   v_sum;
	logic [CW-1:0] committed_n;
	logic [15:0]   exp_total_n;
	logic [7:0]    exp_chunk_n;
	logic [2:0]    verdict;
	logic [31:0]   cc_wide;
	logic [17:0]   raddr_full;

	assign clen_q  = hdr_q[15:0];
	assign chunk_q = hdr_q[23:16];

	// classify the incoming byte by its place in the frame
	always_comb begin
		is_hdr     = fbc_q < cfr_pkg::HDR_BYTES;
		off        = fbc_q - cfr_pkg::HDR_BYTES;
		is_pay     = !is_hdr && (off < {1'b0, clen_q});
		trl_off    = off - {1'b0, clen_q};
		is_trl     = !is_hdr && !is_pay && (trl_off < cfr_pkg::TRL_BYTES);
		base       = (chunk_q == 8'd0) ? 18'd0 : 18'(committed_q);
		waddr_full = base + 18'(off);
		hdr_n      = is_hdr ? {hdr_q[39:0], word.data_byte} : hdr_q;
		crc_n      = is_pay ? cfr_pkg::crc_byte(crc_q, word.data_byte) : crc_q;
		rcrc_n     = is_trl ? {rcrc_q[7:0], word.data_byte} : rcrc_q;
		fbc_n      = (fbc_q != cfr_pkg::COUNT_MAX) ? fbc_q + 17'd1 : fbc_q;
	end

	// frame check at the last byte, in priority order
	always_comb begin
		v_magic     = hdr_n[47:40];
		v_total     = hdr_n[39:24];
		v_chunk     = hdr_n[23:16];
		v_clen      = hdr_n[15:0];
		v_base      = (v_chunk == 8'd0) ? 18'd0 : 18'(committed_q);
		v_sum       = v_base + 18'(v_clen);
		committed_n = committed_q;
		exp_total_n = exp_total_q;
		exp_chunk_n = exp_chunk_q;
		verdict     = cfr_pkg::ST_OK;
		priority if (fbc_n < cfr_pkg::FRAME_MIN || v_magic != magic_q
				|| fbc_n != (17'(v_clen) + cfr_pkg::FRAME_MIN)) begin
			committed_n = '0;
			exp_total_n = '0;
			exp_chunk_n = '0;
			verdict     = cfr_pkg::ST_FRAME_ERR;
		end else if (rcrc_n != crc_n) begin
			verdict = cfr_pkg::ST_CRC_ERR;
		end else if (v_chunk != 8'd0 && (v_chunk != exp_chunk_q || v_total != exp_total_q)) begin
			committed_n = '0;
			exp_total_n = '0;
			exp_chunk_n = '0;
			verdict     = cfr_pkg::ST_FRAME_ERR;
		end else if (v_sum > BUF_LIMIT) begin
			committed_n = '0;
			exp_total_n = '0;
			exp_chunk_n = '0;
			verdict     = cfr_pkg::ST_FRAME_ERR;
		end else begin
			committed_n = v_sum[CW-1:0];
			exp_total_n = v_total;
			exp_chunk_n = v_chunk + 8'd1;
			verdict     = (v_sum >= 18'(v_total)) ? cfr_pkg::ST_DONE : cfr_pkg::ST_OK;
		end
	end

	// speculative payload write and read request
	assign raddr_full = 18'(word.read_address);
	assign ram_we     = accept && (word.command == cfr_pkg::CMD_FRAME) && is_pay
			&& (waddr_full < BUF_LIMIT);
	assign ram_waddr  = waddr_full[AW-1:0];
	assign ram_wdata  = word.data_byte;
	assign ram_re     = accept && (word.command == cfr_pkg::CMD_READ);
	assign ram_raddr  = raddr_full[AW-1:0];

	// result info for the output stage
	always_comb begin
		res_valid = accept && ((word.command == cfr_pkg::CMD_READ)
				|| (word.command == cfr_pkg::CMD_FRAME && word.end_of_frame));
		res.is_read  = (word.command == cfr_pkg::CMD_READ);
		res.in_range = (raddr_full < 18'(committed_q)) && (raddr_full < BUF_LIMIT);
		if (word.command == cfr_pkg::CMD_READ) begin
			res.status         = cfr_pkg::ST_READ;
			res.message_length = exp_total_q;
			cc_wide            = 32'(committed_q);
		end else begin
			res.status         = verdict;
			res.message_length = exp_total_n;
			cc_wide            = 32'(committed_n);
		end
		res.received_count = cc_wide[14:0];
	end

	// state update per accepted word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			committed_q <= '0;
			exp_total_q <= '0;
			exp_chunk_q <= '0;
			fbc_q       <= '0;
			hdr_q       <= '0;
			crc_q       <= cfr_pkg::CRC_INIT;
			rcrc_q      <= '0;
		end else if (accept) begin
			unique case (word.command)
				cfr_pkg::CMD_FRAME: begin
					if (word.end_of_frame) begin
						committed_q <= committed_n;
						exp_total_q <= exp_total_n;
						exp_chunk_q <= exp_chunk_n;
						fbc_q       <= '0;
						hdr_q       <= '0;
						crc_q       <= cfr_pkg::CRC_INIT;
						rcrc_q      <= '0;
					end else begin
						fbc_q  <= fbc_n;
						hdr_q  <= hdr_n;
						crc_q  <= crc_n;
						rcrc_q <= rcrc_n;
					end
				end
				cfr_pkg::CMD_CLEAR: begin
					committed_q <= '0;
					exp_total_q <= '0;
					exp_chunk_q <= '0;
					fbc_q       <= '0;
					hdr_q       <= '0;
					crc_q       <= cfr_pkg::CRC_INIT;
					rcrc_q      <= '0;
				end
				default: begin
				end
			endcase
		end
	end

	// frame magic register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q <= cfr_pkg::MAGIC_RESET;
		end else if (cfg_we) begin
			magic_q <= cfg_data;
		end
	end

endmodule

FILE: design/cfr_out_stage.sv
// ram read stage and output register with backpressure
module cfr_out_stage (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             res_valid,
	input  cfr_pkg::result_t res,
	input  logic [7:0]       ram_rdata,
	output logic             s1_ready,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [2:0]       status,
	output logic [7:0]       read_data,
	output logic [15:0]      message_length,
	output logic [14:0]      received_count
);

	logic             valid_s1;
	cfr_pkg::result_t res_s1;
	logic             out_valid_q;
	logic [2:0]       status_q;
	logic [7:0]       read_data_q;
	logic [15:0]      msg_len_q;
	logic [14:0]      rcv_cnt_q;
	logic             adv;

	assign adv      = !out_valid_q || out_ready;
	assign s1_ready = !valid_s1 || adv;

	// valid flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				valid_s1 <= res_valid;
			end
			if (adv) begin
				out_valid_q <= valid_s1;
			end
		end
	end

	// stage 1 info waits for the ram read data
	always_ff @(posedge clk) begin
		if (s1_ready) begin
			res_s1 <= res;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (adv && valid_s1) begin
			status_q    <= res_s1.status;
			read_data_q <= (res_s1.is_read && res_s1.in_range) ? ram_rdata : 8'd0;
			msg_len_q   <= res_s1.message_length;
			rcv_cnt_q   <= res_s1.received_count;
		end
	end

	assign out_valid      = out_valid_q;
	assign status         = status_q;
	assign read_data      = read_data_q;
	assign message_length = msg_len_q;
	assign received_count = rcv_cnt_q;

endmodule

FILE: design/chunked_frame_reassembler.sv
// top level of the chunked frame reassembler
// result path: a result word passes the stage 1 register and then the output register
// throughput: one input word per cycle while in_ch.ready is high; each word does one
//   state update and at most one buffer ram write or read; output stalls drop ready
// reset: arst_n clears counters, frame state and the magic register (0xA5); buffer ram
//   contents are not cleared, only bytes below the committed count are ever read back
module chunked_frame_reassembler #(
	parameter int BUFFER_BYTES = 16384
) (
	input  logic      clk,
	input  logic      arst_n,
	cfr_in_if.sink    in_ch,
	cfr_out_if.source out_ch,
	cfr_cfg_if.sink   cfg
);

	localparam int AW = $clog2(BUFFER_BYTES);

	cfr_pkg::in_word_t word;
	cfr_pkg::result_t  res;
	logic              accept;
	logic              res_valid;
	logic              s1_ready;
	logic              ram_we;
	logic [AW-1:0]     ram_waddr;
	logic [7:0]        ram_wdata;
	logic              ram_re;
	logic [AW-1:0]     ram_raddr;
	logic [7:0]        ram_rdata;

	// input word handshake
	assign word.command      = in_ch.command;
	assign word.data_byte    = in_ch.data_byte;
	assign word.end_of_frame = in_ch.end_of_frame;
	assign word.read_address = in_ch.read_address;
	assign in_ch.ready       = s1_ready;
	assign accept            = in_ch.valid && s1_ready;
	assign cfg.ready         = 1'b1;

	// parser and reassembly control
	cfr_frame_ctrl #(
		.BUFFER_BYTES(BUFFER_BYTES)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.accept   (accept),
		.word     (word),
		.cfg_we   (cfg.valid),
		.cfg_data (cfg.data),
		.res_valid(res_valid),
		.res      (res),
		.ram_we   (ram_we),
		.ram_waddr(ram_waddr),
		.ram_wdata(ram_wdata),
		.ram_re   (ram_re),
		.ram_raddr(ram_raddr)
	);

	// reassembly buffer
	cfr_ram #(
		.WIDTH(8),
		.DEPTH(BUFFER_BYTES)
	) u_buf (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// result stage
	cfr_out_stage u_out (
		.clk           (clk),
		.arst_n        (arst_n),
		.res_valid     (res_valid),
		.res           (res),
		.ram_rdata     (ram_rdata),
		.s1_ready      (s1_ready),
		.out_ready     (out_ch.ready),
		.out_valid     (out_ch.valid),
		.status        (out_ch.status),
		.read_data     (out_ch.read_data),
		.message_length(out_ch.message_length),
		.received_count(out_ch.received_count)
	);

endmodule

FILE: bench/chunked_frame_reassembler_tb.sv
// self-checking testbench for the chunked frame reassembler
module chunked_frame_reassembler_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int BUF_BYTES = 16384;
	localparam int unsigned RUN_LIMIT = 1000000;
	localparam int HOLD_CYCLES = 400;
	localparam int DRAIN_CYCLES = 8;
	localparam logic [1:0] CMD_NONE = 2'd3;

	typedef struct packed {
		logic [2:0]  status;
		logic [7:0]  read_data;
		logic [15:0] message_length;
		logic [14:0] received_count;
	} result_word_t;

	typedef struct packed {
		cfr_pkg::in_word_t w;
		logic              typed;
		result_word_t      r;
	} plan_row_t;

	typedef enum int {FLAW_NONE, FLAW_MAGIC, FLAW_CRC, FLAW_LONG, FLAW_SHORT} frame_flaw_t;

	// filler for rows checked against the predictor
	localparam result_word_t NO_RES = '{cfr_pkg::ST_OK, 8'h00, 16'h0000, 15'h0000};

	// directed words; result typed in where it is plain, else taken from the predictor
	localparam plan_row_t PLAN [25] = '{
		'{'{cfr_pkg::CMD_READ, 8'h00, 1'b0, 14'h0000}, 1'b1,
			'{cfr_pkg::ST_READ, 8'h00, 16'h0000, 15'h0000}},
		'{'{cfr_pkg::CMD_READ, 8'hFF, 1'b1, 14'h3FFF}, 1'b1,
			'{cfr_pkg::ST_READ, 8'h00, 16'h0000, 15'h0000}},
		'{'{CMD_NONE, 8'hFF, 1'b1, 14'h3FFF}, 1'b0, NO_RES},
		// empty first chunk of an empty message
		'{'{cfr_pkg::CMD_FRAME, cfr_pkg::MAGIC_RESET, 1'b0, 14'h3FFF}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'hFF, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'hFF, 1'b1, 14'h0000}, 1'b1,
			'{cfr_pkg::ST_DONE, 8'h00, 16'h0000, 15'h0000}},
		// frame too short to hold a header
		'{'{cfr_pkg::CMD_FRAME, cfr_pkg::MAGIC_RESET, 1'b1, 14'h0000}, 1'b1,
			'{cfr_pkg::ST_FRAME_ERR, 8'h00, 16'h0000, 15'h0000}},
		// first chunk of two, payload 0xff, crc 0xff00
		'{'{cfr_pkg::CMD_FRAME, cfr_pkg::MAGIC_RESET, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h02, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h01, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'hFF, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'hFF, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_FRAME, 8'h00, 1'b1, 14'h0000}, 1'b0, NO_RES},
		// committed byte, then first byte past the committed count
		'{'{cfr_pkg::CMD_READ, 8'h00, 1'b0, 14'h0000}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_READ, 8'h00, 1'b0, 14'h0001}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_CLEAR, 8'hFF, 1'b1, 14'h3FFF}, 1'b0, NO_RES},
		'{'{cfr_pkg::CMD_READ, 8'h00, 1'b0, 14'h0000}, 1'b1,
			'{cfr_pkg::ST_READ, 8'h00, 16'h0000, 15'h0000}}
	};

	logic clk;
	logic arst_n;

	cfr_in_if  in_ch();
	cfr_out_if out_ch();
	cfr_cfg_if cfg_ch();

	chunked_frame_reassembler #(
		.BUFFER_BYTES(BUF_BYTES)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_ch(in_ch),
		.out_ch(out_ch),
		.cfg(cfg_ch)
	);

	// predictor state
	logic [7:0]  store [BUF_BYTES];
	int unsigned committed;
	int unsigned msg_total;
	int unsigned next_chunk;
	int unsigned frame_count;
	logic [47:0] frame_hdr;
	logic [15:0] crc_run;
	logic [15:0] crc_rx;
	logic [7:0]  frame_magic;

	result_word_t pending_results [$];
	result_word_t head_result;
	int fails;
	int words_sent;
	int hold_req;
	int hold_seen;
	int hold_left;
	bit steady;
	int unsigned cycle_count;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// crc-16/ccitt-false, one input bit at a time
	function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
		logic fb;
		for (int i = 7; i >= 0; i--) begin
			fb = crc[15] ^ b[i];
			crc = {crc[14:0], 1'b0};
			if (fb) begin
				crc = crc ^ cfr_pkg::CRC_POLY;
			end
		end
		return crc;
	endfunction

	function automatic void drop_message();
		committed = 0;
		msg_total = 0;
		next_chunk = 0;
	endfunction

	// advance the predictor by one accepted word; returns 1 when it yields a result
	function automatic bit predict_word(input cfr_pkg::in_word_t w, output result_word_t res);
		int unsigned idx;
		int unsigned clen;
		int unsigned addr;
		logic [7:0]  chunk;
		logic [15:0] total;
		logic [2:0]  st;
		bit          has;
		res = '0;
		has = 1'b0;
		st = cfr_pkg::ST_OK;
		case (w.command)
			cfr_pkg::CMD_FRAME: begin
				idx = frame_count;
				clen = frame_hdr[15:0];
				chunk = frame_hdr[23:16];
				if (idx < cfr_pkg::HDR_BYTES) begin
					frame_hdr = {frame_hdr[39:0], w.data_byte};
				end else if (idx - cfr_pkg::HDR_BYTES < clen) begin
					// speculative payload write
					addr = (chunk == 8'd0 ? 0 : committed) + idx - cfr_pkg::HDR_BYTES;
					crc_run = crc_update(crc_run, w.data_byte);
					if (addr < BUF_BYTES) begin
						store[addr] = w.data_byte;
					end
				end else if (idx - cfr_pkg::HDR_BYTES - clen < cfr_pkg::TRL_BYTES) begin
					crc_rx = {crc_rx[7:0], w.data_byte};
				end
				if (frame_count < cfr_pkg::COUNT_MAX) begin
					frame_count++;
				end
				if (w.end_of_frame) begin
					// frame verdict, checks in priority order
					total = frame_hdr[39:24];
					chunk = frame_hdr[23:16];
					clen = frame_hdr[15:0];
					if (frame_count < cfr_pkg::FRAME_MIN
							|| frame_hdr[47:40] != frame_magic
							|| frame_count != cfr_pkg::HDR_BYTES + clen
							+ cfr_pkg::TRL_BYTES) begin
						drop_message();
						st = cfr_pkg::ST_FRAME_ERR;
					end else if (crc_rx != crc_run) begin
						st = cfr_pkg::ST_CRC_ERR;
					end else if (chunk != 8'd0 &&
							(chunk != next_chunk || total != msg_total)) begin
						drop_message();
						st = cfr_pkg::ST_FRAME_ERR;
					end else begin
						if (chunk == 8'd0) begin
							drop_message();
							msg_total = total;
						end
						if (committed + clen > BUF_BYTES) begin
							drop_message();
							st = cfr_pkg::ST_FRAME_ERR;
						end else begin
							committed = committed + clen;
							next_chunk = (chunk + 1) & 8'hFF;
							st = committed >= msg_total ? cfr_pkg::ST_DONE : cfr_pkg::ST_OK;
						end
					end
					frame_count = 0;
					frame_hdr = '0;
					crc_run = cfr_pkg::CRC_INIT;
					crc_rx = '0;
					has = 1'b1;
				end
			end
			cfr_pkg::CMD_READ: begin
				st = cfr_pkg::ST_READ;
				if (w.read_address < committed && w.read_address < BUF_BYTES) begin
					res.read_data = store[w.read_address];
				end
				has = 1'b1;
			end
			cfr_pkg::CMD_CLEAR: begin
				drop_message();
				frame_count = 0;
				frame_hdr = '0;
				crc_run = cfr_pkg::CRC_INIT;
				crc_rx = '0;
			end
			default: begin
			end
		endcase
		res.status = st;
		res.message_length = msg_total[15:0];
		res.received_count = committed[14:0];
		return has;
	endfunction

	// offer one word at the falling edge and hold it until accepted
	task automatic push_word(input cfr_pkg::in_word_t w, input bit typed = 1'b0,
			input result_word_t typed_res = '0);
		result_word_t res;
		while (!steady && $urandom_range(99) < 37) begin
			in_ch.valid <= 1'b0;
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.command <= w.command;
		in_ch.data_byte <= w.data_byte;
		in_ch.end_of_frame <= w.end_of_frame;
		in_ch.read_address <= w.read_address;
		do @(posedge clk); while (!in_ch.ready);
		if (predict_word(w, res)) begin
			pending_results.push_back(typed ? typed_res : res);
		end
		if (w.command != CMD_NONE) begin
			words_sent++;
		end
		@(negedge clk);
	endtask

	// write the magic register once the block has gone quiet
	task automatic set_magic(input logic [7:0] value);
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
		cfg_ch.valid <= 1'b1;
		cfg_ch.data <= value;
		do @(posedge clk); while (!cfg_ch.ready);
		frame_magic = value;
		@(negedge clk);
		cfg_ch.valid <= 1'b0;
	endtask

	task automatic send_frame(input logic [7:0] chunk, input logic [15:0] total,
			input int plen, input frame_flaw_t flaw);
		logic [7:0]  fb [$];
		logic [15:0] clen;
		logic [15:0] crc;
		logic [7:0]  b;
		clen = 16'(plen);
		fb = {};
		if (flaw == FLAW_MAGIC) begin
			fb.push_back(frame_magic ^ 8'($urandom_range(1, 255)));
		end else begin
			fb.push_back(frame_magic);
		end
		fb.push_back(total[15:8]);
		fb.push_back(total[7:0]);
		fb.push_back(chunk);
		fb.push_back(clen[15:8]);
		fb.push_back(clen[7:0]);
		crc = cfr_pkg::CRC_INIT;
		for (int k = 0; k < plen; k++) begin
			b = 8'($urandom);
			fb.push_back(b);
			crc = crc_update(crc, b);
		end
		if (flaw == FLAW_CRC) begin
			crc = crc ^ 16'($urandom_range(1, 65535));
		end
		fb.push_back(crc[15:8]);
		fb.push_back(crc[7:0]);
		if (flaw == FLAW_LONG) begin
			fb.push_back(8'($urandom));
		end else if (flaw == FLAW_SHORT) begin
			void'(fb.pop_back());
		end
		foreach (fb[k]) begin
			push_word('{cfr_pkg::CMD_FRAME, fb[k], k == fb.size() - 1, 14'($urandom)});
		end
	endtask

	task automatic send_read();
		int unsigned top;
		logic [13:0] addr;
		top = committed + 3;
		if (top > BUF_BYTES - 1) begin
			top = BUF_BYTES - 1;
		end
		if ($urandom_range(99) < 70) begin
			addr = 14'($urandom_range(0, top));
		end else begin
			addr = 14'($urandom);
		end
		push_word('{cfr_pkg::CMD_READ, 8'($urandom), 1'($urandom), addr});
	endtask

	// a run of chunks forming one message, with occasional damage
	task automatic send_message();
		int nchunks;
		int sizes [4];
		int sum;
		int r;
		logic [15:0] total;
		logic [15:0] tfield;
		logic [7:0]  idx;
		frame_flaw_t flaw;
		nchunks = $urandom_range(1, 4);
		sum = 0;
		for (int i = 0; i < nchunks; i++) begin
			sizes[i] = $urandom_range(0, 10);
			sum += sizes[i];
		end
		r = $urandom_range(99);
		if (r < 70) begin
			total = 16'(sum);
		end else if (r < 85) begin
			total = 16'(sum + $urandom_range(1, 5));
		end else begin
			total = 16'($urandom);
		end
		for (int i = 0; i < nchunks; i++) begin
			idx = 8'(i);
			tfield = total;
			flaw = FLAW_NONE;
			r = $urandom_range(99);
			if (r < 5) begin
				idx = 8'(i + $urandom_range(1, 255));
			end else if (r < 10) begin
				tfield = total ^ 16'($urandom_range(1, 65535));
			end else if (r < 25) begin
				flaw = frame_flaw_t'($urandom_range(1, 4));
			end
			send_frame(idx, tfield, sizes[i], flaw);
			if ($urandom_range(99) < 30) begin
				send_read();
			end
		end
	endtask

	// random frame bytes, mostly closed by an end of frame
	task automatic send_noise();
		int n;
		logic [7:0] b;
		logic eof;
		n = $urandom_range(1, 12);
		for (int k = 0; k < n; k++) begin
			b = (k == 0 && $urandom_range(1) == 1) ? frame_magic : 8'($urandom);
			eof = (k == n - 1) ? ($urandom_range(99) < 80) : ($urandom_range(99) < 5);
			push_word('{cfr_pkg::CMD_FRAME, b, eof, 14'($urandom)});
		end
	endtask

	// result side: random back-pressure, one long hold on request
	initial begin
		out_ch.ready = 1'b0;
		hold_seen = 0;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (hold_req != hold_seen) begin
				hold_seen = hold_req;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= steady || $urandom_range(99) >= 37;
			end
		end
	end

	// compare each accepted result word with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (pending_results.size() == 0) begin
				$error("result word with nothing pending: status %0d", out_ch.status);
				fails++;
			end else begin
				head_result = pending_results.pop_front();
				if (out_ch.status !== head_result.status) begin
					$error("status: expected %0d, got %0d", head_result.status, out_ch.status);
					fails++;
				end
				if (out_ch.read_data !== head_result.read_data) begin
					$error("read_data: expected %0h, got %0h",
						head_result.read_data, out_ch.read_data);
					fails++;
				end
				if (out_ch.message_length !== head_result.message_length) begin
					$error("message_length: expected %0d, got %0d",
						head_result.message_length, out_ch.message_length);
					fails++;
				end
				if (out_ch.received_count !== head_result.received_count) begin
					$error("received_count: expected %0d, got %0d",
						head_result.received_count, out_ch.received_count);
					fails++;
				end
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > RUN_LIMIT) begin
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		logic [7:0]  magics [4];
		int goal;
		int r;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.command = cfr_pkg::CMD_FRAME;
		in_ch.data_byte = '0;
		in_ch.end_of_frame = 1'b0;
		in_ch.read_address = '0;
		cfg_ch.valid = 1'b0;
		cfg_ch.data = '0;
		fails = 0;
		words_sent = 0;
		hold_req = 0;
		steady = 1'b0;
		cycle_count = 0;
		drop_message();
		frame_count = 0;
		frame_hdr = '0;
		crc_run = cfr_pkg::CRC_INIT;
		crc_rx = '0;
		frame_magic = cfr_pkg::MAGIC_RESET;

		repeat (9) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed words under the reset magic
		foreach (PLAN[i]) begin
			push_word(PLAN[i].w, PLAN[i].typed, PLAN[i].r);
		end

		// random phases, each under its own magic
		magics = '{8'h00, 8'hFF, 8'($urandom), cfr_pkg::MAGIC_RESET};
		for (int p = 0; p < 4; p++) begin
			set_magic(magics[p]);
			steady = (p == 1);
			if (p == 2) begin
				// stall the result side while reads keep coming
				hold_req++;
				repeat (60) send_read();
			end
			goal = words_sent + 125;
			while (words_sent < goal) begin
				r = $urandom_range(99);
				if (r < 55) begin
					send_message();
				end else if (r < 72) begin
					send_read();
				end else if (r < 78) begin
					push_word('{cfr_pkg::CMD_CLEAR, 8'($urandom), 1'($urandom),
						14'($urandom)});
				end else if (r < 83) begin
					push_word('{CMD_NONE, 8'($urandom), 1'($urandom), 14'($urandom)});
				end else begin
					send_noise();
				end
			end
		end

		// drain and finish
		in_ch.valid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
		if (fails == 0) begin
			$display("*** PASSED ***");
		end else begin
			$display("*** FAILED ***");
		end
		$finish;
	end

endmodule

FILE: files.f
design/cfr_pkg.sv
design/cfr_in_if.sv
design/cfr_out_if.sv
design/cfr_cfg_if.sv
design/cfr_ram.sv
design/cfr_frame_ctrl.sv
design/cfr_out_stage.sv
design/chunked_frame_reassembler.sv
bench/chunked_frame_reassembler_tb.sv
